>>> design/zip_local_header_parser_macros.svh
// Assertion macros for the parser modules; only the parse core uses them.
`ifndef ZIP_LOCAL_HEADER_PARSER_MACROS_SVH
`define ZIP_LOCAL_HEADER_PARSER_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ZLHP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("zlhp assertion failed");

// Condition in one cycle implies a consequence in the next.
`define ZLHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zlhp assertion failed");

`endif

>>> design/zlhp_pkg.sv
// Shared types and constants of the ZIP local header parser.
package zlhp_pkg;

  localparam int HdrLen  = 30;
  localparam int HdrIdxW = $clog2(HdrLen);

  localparam logic [7:0]  SigByte0      = 8'h50;
  localparam logic [7:0]  SigByte1      = 8'h4B;
  localparam logic [7:0]  SigLocal2     = 8'h03;
  localparam logic [7:0]  SigLocal3     = 8'h04;
  localparam logic [15:0] MethodDeflate = 16'd8;
  localparam int          FlagDescBit   = 3;
  localparam logic [7:0]  SlashChar     = 8'h2F;

  typedef enum logic [1:0] {
    KIND_ENTRY   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_SIGNATURE = 2'd1,
    ERR_STREAMED  = 2'd2
  } err_t;

  // Write control from the parse core to the header store.
  typedef struct packed {
    logic               wr;
    logic [HdrIdxW-1:0] idx;
    logic               live_last;
  } hdr_ctrl_t;

  // Decoded view of the 30-byte local header.
  typedef struct packed {
    logic        sig_pk;
    logic        sig_local;
    logic [15:0] flags;
    logic [15:0] method;
    logic [31:0] stamp;
    logic [31:0] csize;
    logic [31:0] usize;
    logic [15:0] nlen;
    logic [15:0] xlen;
  } hdr_info_t;

  typedef struct packed {
    kind_t       kind;
    err_t        error_code;
    logic [15:0] method;
    logic [31:0] packed_size;
    logic [31:0] plain_size;
    logic [31:0] dos_stamp;
    logic [15:0] name_length;
    logic        size_unknown;
    logic        is_dir;
    logic [7:0]  payload;
    logic        last_of_entry;
  } result_t;

endpackage

>>> design/zlhp_hdr.sv
// Header byte store and little-endian field decode.
module zlhp_hdr (
  input  logic                 clk,
  input  logic [7:0]           in_byte,
  input  zlhp_pkg::hdr_ctrl_t  ctrl,
  output zlhp_pkg::hdr_info_t  info
);

  logic [7:0] hdr_mem [zlhp_pkg::HdrLen];
  logic [7:0] last_b;

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      hdr_mem[ctrl.idx] <= in_byte;
    end
  end

  // the final header byte is still on the input when the header completes
  assign last_b = ctrl.live_last ? in_byte : hdr_mem[zlhp_pkg::HdrLen-1];

  always_comb begin
    info.sig_pk    = (hdr_mem[0] == zlhp_pkg::SigByte0) && (hdr_mem[1] == zlhp_pkg::SigByte1);
    info.sig_local = (hdr_mem[2] == zlhp_pkg::SigLocal2) && (hdr_mem[3] == zlhp_pkg::SigLocal3);
    info.flags     = {hdr_mem[7], hdr_mem[6]};
    info.method    = {hdr_mem[9], hdr_mem[8]};
    info.stamp     = {hdr_mem[13], hdr_mem[12], hdr_mem[11], hdr_mem[10]};
    info.csize     = {hdr_mem[21], hdr_mem[20], hdr_mem[19], hdr_mem[18]};
    info.usize     = {hdr_mem[25], hdr_mem[24], hdr_mem[23], hdr_mem[22]};
    info.nlen      = {hdr_mem[27], hdr_mem[26]};
    info.xlen      = {last_b, hdr_mem[28]};
  end

endmodule

>>> design/zlhp_core.sv
// Parse state machine: header, name, extra field, payload and halt.
`include "zip_local_header_parser_macros.svh"

module zlhp_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  input  logic                 restart,
  input  zlhp_pkg::hdr_info_t  info,
  output zlhp_pkg::hdr_ctrl_t  ctrl,
  output logic                 res_valid,
  output zlhp_pkg::result_t    res
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_EXTRA,
    PH_PAYLOAD,
    PH_HALT
  } phase_t;

  localparam int IdxW = zlhp_pkg::HdrIdxW;

  phase_t      phase, phase_next, eff_phase;
  logic [15:0] position, position_next, eff_pos, pos_inc;
  logic [31:0] remaining, remaining_next, rem_dec;
  logic [7:0]  last_name, last_name_next, eff_last, dir_byte;
  logic [IdxW-1:0] hidx;
  logic        do_finish;

  // restart clears parse state ahead of the byte it comes with
  assign eff_phase = restart ? PH_HEADER : phase;
  assign eff_pos   = restart ? 16'd0 : position;
  assign eff_last  = restart ? 8'd0 : last_name;
  assign pos_inc   = eff_pos + 16'd1;
  assign rem_dec   = remaining - 32'd1;
  assign hidx      = (eff_pos < 16'(zlhp_pkg::HdrLen)) ? eff_pos[IdxW-1:0] : '0;

  assign ctrl.wr        = accept && (eff_phase == PH_HEADER);
  assign ctrl.idx       = hidx;
  assign ctrl.live_last = (eff_phase == PH_HEADER);

  always_comb begin
    phase_next     = eff_phase;
    position_next  = eff_pos;
    remaining_next = remaining;
    last_name_next = eff_last;
    dir_byte       = eff_last;
    do_finish      = 1'b0;
    res_valid      = 1'b0;
    res            = '0;
    case (eff_phase)
      PH_HEADER: begin
        if (hidx == IdxW'(zlhp_pkg::HdrLen - 1)) begin
          position_next  = 16'd0;
          last_name_next = 8'd0;
          dir_byte       = 8'd0;
          if (!info.sig_pk) begin
            phase_next     = PH_HALT;
            res_valid      = 1'b1;
            res.kind       = zlhp_pkg::KIND_ERROR;
            res.error_code = zlhp_pkg::ERR_SIGNATURE;
          end else if (!info.sig_local) begin
            phase_next = PH_HALT;
            res_valid  = 1'b1;
            res.kind   = zlhp_pkg::KIND_END;
          end else if (info.flags[zlhp_pkg::FlagDescBit] &&
                       (info.method != zlhp_pkg::MethodDeflate)) begin
            phase_next     = PH_HALT;
            res_valid      = 1'b1;
            res.kind       = zlhp_pkg::KIND_ERROR;
            res.error_code = zlhp_pkg::ERR_STREAMED;
          end else if (info.nlen != 16'd0) begin
            phase_next = PH_NAME;
          end else if (info.xlen != 16'd0) begin
            phase_next = PH_EXTRA;
          end else begin
            do_finish = 1'b1;
          end
        end else begin
          position_next = {{(16-IdxW){1'b0}}, hidx} + 16'd1;
        end
      end
      PH_NAME: begin
        last_name_next = in_byte;
        dir_byte       = in_byte;
        if (pos_inc != info.nlen) begin
          position_next = pos_inc;
        end else begin
          position_next = 16'd0;
          if (info.xlen != 16'd0) begin
            phase_next = PH_EXTRA;
          end else begin
            do_finish = 1'b1;
          end
        end
      end
      PH_EXTRA: begin
        if (pos_inc != info.xlen) begin
          position_next = pos_inc;
        end else begin
          do_finish = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        remaining_next = rem_dec;
        res_valid      = 1'b1;
        res.kind       = zlhp_pkg::KIND_PAYLOAD;
        res.payload    = in_byte;
        if (rem_dec == 32'd0) begin
          res.last_of_entry = 1'b1;
          phase_next        = PH_HEADER;
          position_next     = 16'd0;
        end
      end
      default: begin
        // halted: wait for restart
      end
    endcase

    if (do_finish) begin
      res_valid       = 1'b1;
      res.kind        = zlhp_pkg::KIND_ENTRY;
      res.method      = info.method;
      res.dos_stamp   = info.stamp;
      res.name_length = info.nlen;
      res.is_dir      = (info.nlen != 16'd0) && (dir_byte == zlhp_pkg::SlashChar);
      position_next   = 16'd0;
      if (info.flags[zlhp_pkg::FlagDescBit]) begin
        // streamed deflate: end of data unknown without inflating
        res.size_unknown = 1'b1;
        phase_next       = PH_HALT;
      end else begin
        res.packed_size = info.csize;
        res.plain_size  = info.usize;
        remaining_next  = info.csize;
        phase_next      = (info.csize != 32'd0) ? PH_PAYLOAD : PH_HEADER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      position  <= 16'd0;
      remaining <= 32'd0;
      last_name <= 8'd0;
    end else if (accept) begin
      phase     <= phase_next;
      position  <= position_next;
      remaining <= remaining_next;
      last_name <= last_name_next;
    end
  end

  `ZLHP_ASSERT(a_payload_nonzero, (phase != PH_PAYLOAD) || (remaining != 32'd0))
  `ZLHP_ASSERT(a_hdr_pos_range, (phase != PH_HEADER) || (position < 16'(zlhp_pkg::HdrLen)))
  `ZLHP_ASSERT(a_halt_silent, !((phase == PH_HALT) && !restart && res_valid))
  `ZLHP_ASSERT_NEXT(a_last_rearms, accept && res_valid && res.last_of_entry,
                    (phase == PH_HEADER) && (position == 16'd0))

endmodule

>>> design/zlhp_out.sv
// Result register with backpressure toward the input.
module zlhp_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               res_valid,
  input  zlhp_pkg::result_t  res,
  input  logic               out_stall,
  output logic               out_valid,
  output zlhp_pkg::result_t  res_q,
  output logic               in_stall
);

  logic advance;

  // register may refill whenever it is empty or its transfer completes
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && accept && res_valid) begin
      res_q <= res;
    end
  end

endmodule

>>> design/zip_local_header_parser.sv
// Top level of the ZIP local header parser.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   input   | in        | in_valid / in_stall  | in_byte, restart
//   output  | out       | out_valid / out_stall| kind, error_code, entry fields,
//           |           |                      | payload, last_of_entry
//
// One archive byte is taken per cycle while the input is not stalled; the parse
// state, header store and result are updated in the same cycle, and a result
// appears in the output register in the cycle after its byte's transfer.
// The input stalls only while the output register holds a result that the
// sink is stalling; one result per byte at most, so no queue is needed.
// rst (synchronous) returns to waiting for a header with position, remaining
// count and last name byte cleared; the header byte store is not reset.
// A byte with restart set is parsed as the first byte of a new header.
module zip_local_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [1:0]  error_code,
  output logic [15:0] method,
  output logic [31:0] packed_size,
  output logic [31:0] plain_size,
  output logic [31:0] dos_stamp,
  output logic [15:0] name_length,
  output logic        size_unknown,
  output logic        is_dir,
  output logic [7:0]  payload,
  output logic        last_of_entry
);

  logic                accept;
  logic                res_valid;
  zlhp_pkg::hdr_ctrl_t hdr_ctrl;
  zlhp_pkg::hdr_info_t hdr_info;
  zlhp_pkg::result_t   res;
  zlhp_pkg::result_t   res_q;

  assign accept = in_valid && !in_stall;

  // 30-byte header capture and field decode
  zlhp_hdr u_hdr (
    .clk     (clk),
    .in_byte (in_byte),
    .ctrl    (hdr_ctrl),
    .info    (hdr_info)
  );

  // phase sequencing and result formation
  zlhp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .restart   (restart),
    .info      (hdr_info),
    .ctrl      (hdr_ctrl),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register; its occupancy drives input backpressure
  zlhp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_q     (res_q),
    .in_stall  (in_stall)
  );

  assign kind          = res_q.kind;
  assign error_code    = res_q.error_code;
  assign method        = res_q.method;
  assign packed_size   = res_q.packed_size;
  assign plain_size    = res_q.plain_size;
  assign dos_stamp     = res_q.dos_stamp;
  assign name_length   = res_q.name_length;
  assign size_unknown  = res_q.size_unknown;
  assign is_dir        = res_q.is_dir;
  assign payload       = res_q.payload;
  assign last_of_entry = res_q.last_of_entry;

endmodule
